FILE: src/dfvc_pkg.sv
// Shared types, register indexes and width helpers for the feedforward velocity controller.
package dfvc_pkg;

  localparam int STAGES = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W = 24;
  localparam int SPEED_W = 16;
  localparam int DRIVE_W = 16;

  // Measured speed times ratio is 16 + 25 bits; after dropping 16 fraction bits
  // with rounding headroom the current wheel speed fits in 26 bits.
  localparam int CUR_W = 26;

  localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 16'sd32512;

  localparam logic [CFG_INDEX_W-1:0] REG_TURN_SCALE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_RATIO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STATIC_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_GAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_UP_GAIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_DOWN_GAIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN = 3'd6;

  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
  } pipe_en_t;

  // Width of the velocity error term for a given target width.
  function automatic int err_width(input int w);
    err_width = ((w > CUR_W) ? w : CUR_W) + 1;
  endfunction

  // Width of the Q.24 sum: widest product plus two bits for adding four terms.
  function automatic int sum_width(input int w);
    sum_width = GAIN_W + 1 + err_width(w) + 2;
  endfunction

endpackage

FILE: src/dfvc_split.sv
// Splits the chassis command into left and right wheel velocity and acceleration targets.
module dfvc_split #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                clk,
  input  dfvc_pkg::pipe_en_t                  en,
  input  logic [dfvc_pkg::GAIN_W-1:0]         turn_scale,
  input  logic signed [VALUE_WIDTH-1:0]       linear_vel,
  input  logic signed [VALUE_WIDTH-1:0]       turn_vel,
  input  logic signed [VALUE_WIDTH-1:0]       linear_acc,
  input  logic signed [VALUE_WIDTH-1:0]       turn_acc,
  output logic signed [VALUE_WIDTH-1:0]       left_vel,
  output logic signed [VALUE_WIDTH-1:0]       right_vel,
  output logic signed [VALUE_WIDTH-1:0]       left_acc,
  output logic signed [VALUE_WIDTH-1:0]       right_acc
);

  localparam int P_W = VALUE_WIDTH + dfvc_pkg::GAIN_W + 1;
  localparam int D_W = P_W + 1 - 16;
  localparam int T_W = D_W + 1;

  logic signed [P_W-1:0] vel_prod;
  logic signed [P_W-1:0] acc_prod;
  logic signed [VALUE_WIDTH-1:0] lin_vel;
  logic signed [VALUE_WIDTH-1:0] lin_acc;

  logic signed [P_W:0] vel_round;
  logic signed [P_W:0] acc_round;
  logic signed [D_W-1:0] vel_diff;
  logic signed [D_W-1:0] acc_diff;
  logic signed [VALUE_WIDTH-1:0] left_vel_next;
  logic signed [VALUE_WIDTH-1:0] right_vel_next;
  logic signed [VALUE_WIDTH-1:0] left_acc_next;
  logic signed [VALUE_WIDTH-1:0] right_acc_next;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_target(
    input logic signed [T_W-1:0] x
  );
    logic [T_W-VALUE_WIDTH:0] top;
    top = x[T_W-1:VALUE_WIDTH-1];
    if ((&top) || !(|top)) begin
      sat_target = x[VALUE_WIDTH-1:0];
    end else if (x[T_W-1]) begin
      sat_target = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      sat_target = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en.st1) begin
      vel_prod <= $signed({1'b0, turn_scale}) * turn_vel;
      acc_prod <= $signed({1'b0, turn_scale}) * turn_acc;
      lin_vel <= linear_vel;
      lin_acc <= linear_acc;
    end
  end

  always_comb begin
    vel_round = (P_W + 1)'(vel_prod) + (P_W + 1)'(32768);
    acc_round = (P_W + 1)'(acc_prod) + (P_W + 1)'(32768);
    vel_diff = $signed(vel_round[P_W:16]);
    acc_diff = $signed(acc_round[P_W:16]);
    left_vel_next = sat_target(T_W'(lin_vel) - T_W'(vel_diff));
    right_vel_next = sat_target(T_W'(lin_vel) + T_W'(vel_diff));
    left_acc_next = sat_target(T_W'(lin_acc) - T_W'(acc_diff));
    right_acc_next = sat_target(T_W'(lin_acc) + T_W'(acc_diff));
  end

  always_ff @(posedge clk) begin
    if (en.st2) begin
      left_vel <= left_vel_next;
      right_vel <= right_vel_next;
      left_acc <= left_acc_next;
      right_acc <= right_acc_next;
    end
  end

endmodule

FILE: src/dfvc_lane.sv
// One wheel lane: scales the measured speed and forms the four drive terms as two partial sums.
module dfvc_lane #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                          clk,
  input  dfvc_pkg::pipe_en_t                            en,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   speed_to_inch_ratio,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   static_gain,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   velocity_gain,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   accel_up_gain,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   accel_down_gain,
  input  logic [dfvc_pkg::GAIN_W-1:0]                   proportional_gain,
  input  logic signed [dfvc_pkg::SPEED_W-1:0]           measured_speed,
  input  logic signed [VALUE_WIDTH-1:0]                 target_vel,
  input  logic signed [VALUE_WIDTH-1:0]                 target_acc,
  output logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] ff_sum,
  output logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] fb_sum
);

  localparam int M_W = dfvc_pkg::SPEED_W + dfvc_pkg::GAIN_W + 1;
  localparam int C_W = dfvc_pkg::CUR_W;
  localparam int E_W = dfvc_pkg::err_width(VALUE_WIDTH);
  localparam int S_W = dfvc_pkg::sum_width(VALUE_WIDTH);
  localparam int KS_W = dfvc_pkg::GAIN_W + 9;

  logic signed [M_W-1:0] meas_prod;
  logic signed [M_W:0] meas_round;
  logic signed [C_W-1:0] cur_speed;

  logic signed [E_W-1:0] vel_err;
  logic [dfvc_pkg::GAIN_W-1:0] acc_gain;
  logic signed [KS_W-1:0] ks_pos;
  logic signed [S_W-1:0] ks_term;
  logic signed [S_W-1:0] kv_term;
  logic signed [S_W-1:0] ka_term;
  logic signed [S_W-1:0] kp_term;

  always_ff @(posedge clk) begin
    if (en.st1) begin
      meas_prod <= measured_speed * $signed({1'b0, speed_to_inch_ratio});
    end
  end

  assign meas_round = (M_W + 1)'(meas_prod) + (M_W + 1)'(32768);

  always_ff @(posedge clk) begin
    if (en.st2) begin
      cur_speed <= $signed(meas_round[M_W:16]);
    end
  end

  always_comb begin
    vel_err = E_W'(target_vel) - E_W'(cur_speed);
    // Zero acceleration takes the down gain, like any negative value.
    if (!target_acc[VALUE_WIDTH-1] && (target_acc != '0)) begin
      acc_gain = accel_up_gain;
    end else begin
      acc_gain = accel_down_gain;
    end
    ks_pos = $signed({1'b0, static_gain, 8'b0});
  end

  always_ff @(posedge clk) begin
    if (en.st3) begin
      if (target_vel == '0) begin
        ks_term <= '0;
      end else if (target_vel[VALUE_WIDTH-1]) begin
        ks_term <= -S_W'(ks_pos);
      end else begin
        ks_term <= S_W'(ks_pos);
      end
      kv_term <= S_W'($signed({1'b0, velocity_gain}) * target_vel);
      ka_term <= S_W'($signed({1'b0, acc_gain}) * target_acc);
      kp_term <= S_W'($signed({1'b0, proportional_gain}) * vel_err);
    end
  end

  always_ff @(posedge clk) begin
    if (en.st4) begin
      ff_sum <= ks_term + kv_term;
      fb_sum <= ka_term + kp_term;
    end
  end

endmodule

FILE: src/dfvc_merge.sv
// Final stage: adds each lane's partial sums, rounds to Q8.8, saturates, and holds the result.
module dfvc_merge #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                               clk,
  input  dfvc_pkg::pipe_en_t                                 en,
  input  logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] left_ff,
  input  logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] left_fb,
  input  logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] right_ff,
  input  logic signed [dfvc_pkg::sum_width(VALUE_WIDTH)-1:0] right_fb,
  output logic signed [dfvc_pkg::DRIVE_W-1:0]                left_drive,
  output logic signed [dfvc_pkg::DRIVE_W-1:0]                right_drive
);

  localparam int S_W = dfvc_pkg::sum_width(VALUE_WIDTH);
  localparam int R_W = S_W + 1 - 16;
  localparam logic signed [R_W-1:0] LIM_HI = R_W'(dfvc_pkg::DRIVE_LIMIT);
  localparam logic signed [R_W-1:0] LIM_LO = -LIM_HI;

  function automatic logic signed [dfvc_pkg::DRIVE_W-1:0] finish(
    input logic signed [S_W-1:0] ff,
    input logic signed [S_W-1:0] fb
  );
    logic signed [S_W:0] total;
    logic signed [R_W-1:0] rounded;
    total = (S_W + 1)'(ff) + (S_W + 1)'(fb) + (S_W + 1)'(32768);
    rounded = $signed(total[S_W:16]);
    if (rounded > LIM_HI) begin
      finish = dfvc_pkg::DRIVE_LIMIT;
    end else if (rounded < LIM_LO) begin
      finish = -dfvc_pkg::DRIVE_LIMIT;
    end else begin
      finish = rounded[dfvc_pkg::DRIVE_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en.st5) begin
      left_drive <= finish(left_ff, left_fb);
      right_drive <= finish(right_ff, right_fb);
    end
  end

endmodule

FILE: src/differential_feedforward_velocity_ctrl_unit.sv
// Top level: configuration registers, pipeline valid tracking, split stage, two lanes and merge.
// Commands pass the five pipeline registers in order: input products, wheel targets and
// scaled speed, lane terms, partial sums, merged drive; each register holds one transaction.
// Throughput: one command per cycle unless a stalled output has filled the pipeline.
// A stalled output only holds the stages behind it once every stage in between is full.
// Reset (synchronous, active high) clears all gain registers to zero and empties the pipeline.
module differential_feedforward_velocity_ctrl_unit #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [dfvc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [dfvc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    cmd_valid,
  output logic                                    cmd_ready,
  input  logic signed [VALUE_WIDTH-1:0]           linear_vel,
  input  logic signed [VALUE_WIDTH-1:0]           turn_vel,
  input  logic signed [VALUE_WIDTH-1:0]           linear_acc,
  input  logic signed [VALUE_WIDTH-1:0]           turn_acc,
  input  logic signed [dfvc_pkg::SPEED_W-1:0]     left_measured_speed,
  input  logic signed [dfvc_pkg::SPEED_W-1:0]     right_measured_speed,
  output logic                                    drive_valid,
  input  logic                                    drive_ready,
  output logic signed [dfvc_pkg::DRIVE_W-1:0]     left_drive,
  output logic signed [dfvc_pkg::DRIVE_W-1:0]     right_drive
);

  localparam int S_W = dfvc_pkg::sum_width(VALUE_WIDTH);
  localparam int NS = dfvc_pkg::STAGES;

  logic [dfvc_pkg::GAIN_W-1:0] turn_scale;
  logic [dfvc_pkg::GAIN_W-1:0] speed_to_inch_ratio;
  logic [dfvc_pkg::GAIN_W-1:0] static_gain;
  logic [dfvc_pkg::GAIN_W-1:0] velocity_gain;
  logic [dfvc_pkg::GAIN_W-1:0] accel_up_gain;
  logic [dfvc_pkg::GAIN_W-1:0] accel_down_gain;
  logic [dfvc_pkg::GAIN_W-1:0] proportional_gain;

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;
  dfvc_pkg::pipe_en_t en;

  logic signed [VALUE_WIDTH-1:0] left_vel;
  logic signed [VALUE_WIDTH-1:0] right_vel;
  logic signed [VALUE_WIDTH-1:0] left_acc;
  logic signed [VALUE_WIDTH-1:0] right_acc;
  logic signed [S_W-1:0] left_ff;
  logic signed [S_W-1:0] left_fb;
  logic signed [S_W-1:0] right_ff;
  logic signed [S_W-1:0] right_fb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_scale <= '0;
      speed_to_inch_ratio <= '0;
      static_gain <= '0;
      velocity_gain <= '0;
      accel_up_gain <= '0;
      accel_down_gain <= '0;
      proportional_gain <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dfvc_pkg::REG_TURN_SCALE:      turn_scale <= cfg_data;
        dfvc_pkg::REG_SPEED_RATIO:     speed_to_inch_ratio <= cfg_data;
        dfvc_pkg::REG_STATIC_GAIN:     static_gain <= cfg_data;
        dfvc_pkg::REG_VELOCITY_GAIN:   velocity_gain <= cfg_data;
        dfvc_pkg::REG_ACCEL_UP_GAIN:   accel_up_gain <= cfg_data;
        dfvc_pkg::REG_ACCEL_DOWN_GAIN: accel_down_gain <= cfg_data;
        dfvc_pkg::REG_PROP_GAIN:       proportional_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it is moving on,
  // so bubbles are squeezed out while the output waits.
  always_comb begin
    adv[NS-1] = !vld[NS-1] || drive_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    en.st1 = adv[0];
    en.st2 = adv[1];
    en.st3 = adv[2];
    en.st4 = adv[3];
    en.st5 = adv[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= cmd_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign cmd_ready = adv[0];
  assign drive_valid = vld[NS-1];

  dfvc_split #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_split (
    .clk(clk),
    .en(en),
    .turn_scale(turn_scale),
    .linear_vel(linear_vel),
    .turn_vel(turn_vel),
    .linear_acc(linear_acc),
    .turn_acc(turn_acc),
    .left_vel(left_vel),
    .right_vel(right_vel),
    .left_acc(left_acc),
    .right_acc(right_acc)
  );

  dfvc_lane #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lane_left (
    .clk(clk),
    .en(en),
    .speed_to_inch_ratio(speed_to_inch_ratio),
    .static_gain(static_gain),
    .velocity_gain(velocity_gain),
    .accel_up_gain(accel_up_gain),
    .accel_down_gain(accel_down_gain),
    .proportional_gain(proportional_gain),
    .measured_speed(left_measured_speed),
    .target_vel(left_vel),
    .target_acc(left_acc),
    .ff_sum(left_ff),
    .fb_sum(left_fb)
  );

  dfvc_lane #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lane_right (
    .clk(clk),
    .en(en),
    .speed_to_inch_ratio(speed_to_inch_ratio),
    .static_gain(static_gain),
    .velocity_gain(velocity_gain),
    .accel_up_gain(accel_up_gain),
    .accel_down_gain(accel_down_gain),
    .proportional_gain(proportional_gain),
    .measured_speed(right_measured_speed),
    .target_vel(right_vel),
    .target_acc(right_acc),
    .ff_sum(right_ff),
    .fb_sum(right_fb)
  );

  dfvc_merge #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_merge (
    .clk(clk),
    .en(en),
    .left_ff(left_ff),
    .left_fb(left_fb),
    .right_ff(right_ff),
    .right_fb(right_fb),
    .left_drive(left_drive),
    .right_drive(right_drive)
  );

  // A stage that was holding a transaction and could not advance still holds it.
  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((vld & $past(vld & ~adv)) == $past(vld & ~adv)))
    else $error("stalled pipeline stage lost its transaction");

  // Any empty stage lets a new command in.
  a_bubble_accepts: assert property (@(posedge clk) disable iff (rst)
    !(&vld) |-> cmd_ready)
    else $error("command refused while the pipeline had room");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> vld[0])
    else $error("accepted command did not enter the first stage");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (left_drive <= dfvc_pkg::DRIVE_LIMIT) &&
                    (left_drive >= -dfvc_pkg::DRIVE_LIMIT) &&
                    (right_drive <= dfvc_pkg::DRIVE_LIMIT) &&
                    (right_drive >= -dfvc_pkg::DRIVE_LIMIT))
    else $error("drive value outside the saturation limits");

  a_cfg_turn_scale: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_index == dfvc_pkg::REG_TURN_SCALE) |=>
      turn_scale == $past(cfg_data))
    else $error("turn scale write not taken");

endmodule

FILE: bench/tb_differential_feedforward_velocity_ctrl_unit.sv
// Self-checking testbench for the feedforward velocity controller with a drive-value scoreboard.
module tb_differential_feedforward_velocity_ctrl_unit;

  localparam int VW = 24;
  localparam longint VAL_MAX = (longint'(1) << (VW - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int RANDOM_PHASES = 6;
  localparam logic [dfvc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic signed [VW-1:0] VMAX = 24'sh7FFFFF;
  localparam logic signed [VW-1:0] VMIN = 24'sh800000;
  localparam logic signed [dfvc_pkg::SPEED_W-1:0] SMAX = 16'sh7FFF;
  localparam logic signed [dfvc_pkg::SPEED_W-1:0] SMIN = 16'sh8000;

  typedef struct packed {
    logic signed [VW-1:0]                lin_vel;
    logic signed [VW-1:0]                turn_vel;
    logic signed [VW-1:0]                lin_acc;
    logic signed [VW-1:0]                turn_acc;
    logic signed [dfvc_pkg::SPEED_W-1:0] left_meas;
    logic signed [dfvc_pkg::SPEED_W-1:0] right_meas;
  } command_t;

  typedef struct {
    logic signed [dfvc_pkg::DRIVE_W-1:0] left_drv;
    logic signed [dfvc_pkg::DRIVE_W-1:0] right_drv;
  } drive_pair_t;

  // Holds a copy of the gain registers and the drive values still owed by the block.
  class drive_scoreboard;
    longint turn_scale, inch_ratio, ks, kv, ka_up, ka_down, kp;
    drive_pair_t expected_drives[$];
    int mismatches;

    function new();
      turn_scale = 0; inch_ratio = 0; ks = 0; kv = 0;
      ka_up = 0; ka_down = 0; kp = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [dfvc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [dfvc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        dfvc_pkg::REG_TURN_SCALE: begin
          turn_scale = longint'(val);
        end
        dfvc_pkg::REG_SPEED_RATIO: begin
          inch_ratio = longint'(val);
        end
        dfvc_pkg::REG_STATIC_GAIN: begin
          ks = longint'(val);
        end
        dfvc_pkg::REG_VELOCITY_GAIN: begin
          kv = longint'(val);
        end
        dfvc_pkg::REG_ACCEL_UP_GAIN: begin
          ka_up = longint'(val);
        end
        dfvc_pkg::REG_ACCEL_DOWN_GAIN: begin
          ka_down = longint'(val);
        end
        dfvc_pkg::REG_PROP_GAIN: begin
          kp = longint'(val);
        end
        default: begin
        end
      endcase
    endfunction

    // Round to nearest with ties toward plus infinity; >>> on longint is a floor.
    function longint round_q(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint wheel(longint base, longint turn, bit right_side);
      longint d;
      d = round_q(turn_scale * turn, 16);
      return clamp(right_side ? base + d : base - d, VAL_MIN, VAL_MAX);
    endfunction

    function logic signed [dfvc_pkg::DRIVE_W-1:0] side_drive(longint v, longint a,
                                                             longint meas);
      longint cur, err, sgn, gain_a, sum, r;
      cur = round_q(meas * inch_ratio, 16);
      err = v - cur;
      sgn = (v > 0) ? 1 : ((v < 0) ? -1 : 0);
      gain_a = (a > 0) ? ka_up : ka_down;
      sum = sgn * ks * 256 + kv * v + gain_a * a + kp * err;
      r = clamp(round_q(sum, 16), -longint'(dfvc_pkg::DRIVE_LIMIT),
                longint'(dfvc_pkg::DRIVE_LIMIT));
      return r[dfvc_pkg::DRIVE_W-1:0];
    endfunction

    function void note_command(command_t c);
      longint vl, vr, al, ar;
      drive_pair_t d;
      vl = wheel(longint'(c.lin_vel), longint'(c.turn_vel), 1'b0);
      vr = wheel(longint'(c.lin_vel), longint'(c.turn_vel), 1'b1);
      al = wheel(longint'(c.lin_acc), longint'(c.turn_acc), 1'b0);
      ar = wheel(longint'(c.lin_acc), longint'(c.turn_acc), 1'b1);
      d.left_drv = side_drive(vl, al, longint'(c.left_meas));
      d.right_drv = side_drive(vr, ar, longint'(c.right_meas));
      expected_drives.push_back(d);
    endfunction

    function void check_drive(logic signed [dfvc_pkg::DRIVE_W-1:0] l,
                              logic signed [dfvc_pkg::DRIVE_W-1:0] r);
      drive_pair_t e;
      if (expected_drives.size() == 0) begin
        $display("%0t: drive transaction with no command outstanding: left %0d right %0d",
                 $time, l, r);
        mismatches++;
        return;
      end
      e = expected_drives.pop_front();
      if (l !== e.left_drv) begin
        $display("%0t: left_drive expected %0d, got %0d", $time, e.left_drv, l);
        mismatches++;
      end
      if (r !== e.right_drv) begin
        $display("%0t: right_drive expected %0d, got %0d", $time, e.right_drv, r);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [dfvc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dfvc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic cmd_valid;
  logic cmd_ready;
  logic signed [VW-1:0] linear_vel;
  logic signed [VW-1:0] turn_vel;
  logic signed [VW-1:0] linear_acc;
  logic signed [VW-1:0] turn_acc;
  logic signed [dfvc_pkg::SPEED_W-1:0] left_measured_speed;
  logic signed [dfvc_pkg::SPEED_W-1:0] right_measured_speed;
  logic drive_valid;
  logic drive_ready;
  logic signed [dfvc_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dfvc_pkg::DRIVE_W-1:0] right_drive;

  drive_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int cycle_count = 0;

  differential_feedforward_velocity_ctrl_unit #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .linear_vel(linear_vel),
    .turn_vel(turn_vel),
    .linear_acc(linear_acc),
    .turn_acc(turn_acc),
    .left_measured_speed(left_measured_speed),
    .right_measured_speed(right_measured_speed),
    .drive_valid(drive_valid),
    .drive_ready(drive_ready),
    .left_drive(left_drive),
    .right_drive(right_drive)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every handshake is sampled at the edge, so the values seen are the ones before it.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (cmd_valid && cmd_ready) begin
        sb.note_command(command_t'{linear_vel, turn_vel, linear_acc, turn_acc,
                                   left_measured_speed, right_measured_speed});
      end
      if (drive_valid && drive_ready) sb.check_drive(left_drive, right_drive);
    end
  end

  // Result side: random backpressure, plus one long hold when it is requested.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    drive_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0 && !hold_taken) begin
        hold_left = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        drive_ready <= 1'b0;
        hold_left--;
      end else begin
        drive_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [31:0] rand_field(input int w);
    logic [31:0] top;
    top = 32'd1 << (w - 1);
    case ($urandom_range(9))
      0: rand_field = '0;
      1: rand_field = top - 1;
      2: rand_field = top;
      3, 4, 5: rand_field = $urandom_range(0, 8191) - 4096;
      default: rand_field = $urandom();
    endcase
  endfunction

  function automatic command_t rand_command();
    command_t c;
    logic [31:0] v;
    v = rand_field(VW); c.lin_vel = v[VW-1:0];
    v = rand_field(VW); c.turn_vel = v[VW-1:0];
    v = rand_field(VW); c.lin_acc = v[VW-1:0];
    v = rand_field(VW); c.turn_acc = v[VW-1:0];
    v = rand_field(dfvc_pkg::SPEED_W); c.left_meas = v[dfvc_pkg::SPEED_W-1:0];
    v = rand_field(dfvc_pkg::SPEED_W); c.right_meas = v[dfvc_pkg::SPEED_W-1:0];
    return c;
  endfunction

  function automatic logic [dfvc_pkg::CFG_DATA_W-1:0] phase_gain(input int phase);
    case (phase)
      0, 4: phase_gain = dfvc_pkg::CFG_DATA_W'($urandom_range(0, 24'h030000));
      1: phase_gain = 24'hFFFFFF;
      3: phase_gain = '0;
      default: begin
        case ($urandom_range(3))
          0: phase_gain = '0;
          1: phase_gain = 24'hFFFFFF;
          2: phase_gain = dfvc_pkg::CFG_DATA_W'($urandom_range(0, 24'h030000));
          default: phase_gain = dfvc_pkg::CFG_DATA_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // Leaves cfg_valid high so that writes can follow back to back; the caller drops it.
  task automatic write_reg(input logic [dfvc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [dfvc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_command(input command_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    linear_vel <= c.lin_vel;
    turn_vel <= c.turn_vel;
    linear_acc <= c.lin_acc;
    turn_acc <= c.turn_acc;
    left_measured_speed <= c.left_meas;
    right_measured_speed <= c.right_meas;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    command_t directed[$];
    int phase;
    int n;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_valid = 1'b0;
    linear_vel = '0;
    turn_vel = '0;
    linear_acc = '0;
    turn_acc = '0;
    left_measured_speed = '0;
    right_measured_speed = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Moderate gains: turn scale 2.0, so a turn of half the linear speed zeroes one wheel.
    write_reg(dfvc_pkg::REG_TURN_SCALE, 24'h020000);
    write_reg(dfvc_pkg::REG_SPEED_RATIO, 24'h100000);
    write_reg(dfvc_pkg::REG_STATIC_GAIN, 24'h008000);
    write_reg(dfvc_pkg::REG_VELOCITY_GAIN, 24'h010000);
    write_reg(dfvc_pkg::REG_ACCEL_UP_GAIN, 24'h004000);
    write_reg(dfvc_pkg::REG_ACCEL_DOWN_GAIN, 24'h002000);
    write_reg(dfvc_pkg::REG_PROP_GAIN, 24'h003000);
    // A write to an index with no register behind it must change nothing.
    write_reg(REG_UNMAPPED, 24'hFFFFFF);
    cfg_valid <= 1'b0;

    directed.push_back(command_t'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0});
    directed.push_back(command_t'{VMAX, VMAX, VMAX, VMAX, SMAX, SMAX});
    directed.push_back(command_t'{VMIN, VMIN, VMIN, VMIN, SMIN, SMIN});
    directed.push_back(command_t'{VMAX, VMIN, VMIN, VMAX, SMIN, SMAX});
    directed.push_back(command_t'{VMIN, VMAX, VMAX, VMIN, SMAX, SMIN});
    directed.push_back(command_t'{24'sd0, 24'sd0, 24'sh000400, 24'sd0, 16'sd100, -16'sd100});
    directed.push_back(command_t'{24'sh000A00, 24'sh000080, 24'sd0, 24'sd0, 16'sd0, 16'sd0});
    directed.push_back(command_t'{24'sh000A00, -24'sh000040, -24'sh000300, 24'sh000010,
                                  16'sd40, 16'sd45});
    directed.push_back(command_t'{-24'sh000800, 24'sh000020, 24'sh000200, -24'sh000020,
                                  -16'sd30, -16'sd35});
    directed.push_back(command_t'{24'sh000100, 24'sh000080, 24'sh000100, 24'sh000080,
                                  16'sd1, -16'sd1});
    directed.push_back(command_t'{24'sh000100, -24'sh000080, -24'sh000100, 24'sh000080,
                                  16'sd2, 16'sd3});
    directed.push_back(command_t'{24'sh000010, 24'sd1, 24'sd1, -24'sd1, SMAX, SMIN});
    directed.push_back(command_t'{-24'sd1, 24'sd0, -24'sd1, 24'sd0, SMIN, SMAX});
    directed.push_back(command_t'{24'sh001000, 24'sh000100, -24'sh001000, -24'sh000100,
                                  16'sd500, -16'sd500});
    directed.push_back(command_t'{24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'shD55555,
                                  16'sh5555, 16'shAAAA});
    foreach (directed[i]) send_command(directed[i]);
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_reg(dfvc_pkg::REG_TURN_SCALE, phase_gain(phase));
      write_reg(dfvc_pkg::REG_SPEED_RATIO, phase_gain(phase));
      write_reg(dfvc_pkg::REG_STATIC_GAIN, phase_gain(phase));
      write_reg(dfvc_pkg::REG_VELOCITY_GAIN, phase_gain(phase));
      write_reg(dfvc_pkg::REG_ACCEL_UP_GAIN, phase_gain(phase));
      write_reg(dfvc_pkg::REG_ACCEL_DOWN_GAIN, phase_gain(phase));
      write_reg(dfvc_pkg::REG_PROP_GAIN, phase_gain(phase));
      cfg_valid <= 1'b0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // With no idling on either side, a long output stall fills the pipeline.
        if (phase == RANDOM_PHASES - 2 && n == 40) hold_request = 300;
        send_command(rand_command());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: differential_feedforward_velocity_ctrl_unit.f
src/dfvc_pkg.sv
src/dfvc_split.sv
src/dfvc_lane.sv
src/dfvc_merge.sv
src/differential_feedforward_velocity_ctrl_unit.sv
bench/tb_differential_feedforward_velocity_ctrl_unit.sv
